FILE: src/hbm_pkg.sv
// shared constants, types and helpers of the bucketed hash map
package hbm_pkg;

    localparam int BUCKETS     = 16;
    localparam int WAYS        = 4;
    localparam int SLOTS       = BUCKETS * WAYS;

    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 7;
    localparam int OP_W        = 3;

    localparam int BUCKET_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int BUCKET_WIDE = BUCKET_W + 1;
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_W      = $clog2(SLOTS);

    // bucket index is just the low key bits when the bucket count is a power of two
    localparam bit BUCKET_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    // digit-serial remainder for other bucket counts
    localparam int HASH_BITS   = 8;
    localparam int HASH_STEPS  = KEY_W / HASH_BITS;
    localparam int HASH_CNT_W  = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

    // 2^32 mod BUCKETS, used to fold a negative key into a non-negative remainder
    localparam logic [BUCKET_W-1:0] WRAP_MOD = BUCKET_W'((64'd1 << KEY_W) % BUCKETS);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_GET    = 3'd2,
        OP_EXISTS = 3'd3,
        OP_UPDATE = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EXISTS  = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic accept;
        logic hash_step;
        logic read;
        logic finish;
    } hbm_cmd_t;

    typedef struct packed {
        logic hash_last;
        logic last_way;
        logic out_busy;
    } hbm_stat_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [BUCKET_W-1:0] bucket,
                                                  input logic [WAY_W-1:0] way);
        return SLOT_W'(bucket) * SLOT_W'(WAYS) + SLOT_W'(way);
    endfunction

endpackage

FILE: src/hbm_ram.sv
// generic single-write, single-read ram with registered read data
module hbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/hbm_ctrl.sv
// request sequencer of the bucketed hash map
module hbm_ctrl
    import hbm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  hbm_stat_t stat,
    output hbm_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_HASH   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = BUCKET_POW2 ? S_SEARCH : S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last) begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmd.read = 1'b1;
                if (stat.last_way) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

FILE: src/hbm_datapath.sv
// bucket hashing, way search, slot stores and result register
module hbm_datapath
    import hbm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hbm_cmd_t                  cmd,
    output hbm_stat_t                 stat,
    input  logic [OP_W-1:0]           s_operation,
    input  logic signed [KEY_W-1:0]   s_key,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic                      m_ready,
    output logic                      m_valid,
    output logic [1:0]                m_status,
    output logic signed [VALUE_W-1:0] m_read_value,
    output logic [COUNT_W-1:0]        m_entry_count
);

    op_t                    op_reg, op_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [BUCKET_W-1:0]    bucket_reg, bucket_next;
    logic [HASH_CNT_W-1:0]  hash_cnt_reg, hash_cnt_next;
    logic [WAY_W-1:0]       way_reg, way_next;
    logic [WAY_W-1:0]       cmp_way_reg, cmp_way_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic                   hit_reg, hit_next;
    logic [WAY_W-1:0]       hit_way_reg, hit_way_next;
    logic [VALUE_W-1:0]     hit_value_reg, hit_value_next;
    logic [SLOTS-1:0]       valid_reg, valid_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   m_valid_reg, m_valid_next;
    status_t                status_reg, status_next;
    logic [VALUE_W-1:0]     read_value_reg, read_value_next;

    logic [KEY_W-1:0]       key_rd;
    logic [VALUE_W-1:0]     value_rd;
    logic [KEY_W-1:0]       hash_shift;
    logic [HASH_BITS-1:0]   hash_byte;
    logic [BUCKET_W-1:0]    rem;
    logic [BUCKET_WIDE-1:0] rem_wide;
    logic [BUCKET_W-1:0]    hash_result;
    logic                   match_now;
    logic                   hit_now;
    logic [WAY_W-1:0]       hit_way_now;
    logic [VALUE_W-1:0]     hit_value_now;
    logic [WAYS-1:0]        bucket_valid;
    logic                   free_any;
    logic [WAY_W-1:0]       free_way;
    logic                   key_wr_en;
    logic                   value_wr_en;
    logic [SLOT_W-1:0]      free_slot;
    logic [SLOT_W-1:0]      hit_slot;

    // one key byte per cycle, one remainder bit per inner step
    always_comb begin
        hash_shift = key_reg >> (HASH_BITS * (HASH_STEPS - 1 - int'(hash_cnt_reg)));
        hash_byte  = hash_shift[HASH_BITS-1:0];
        rem        = (hash_cnt_reg == '0) ? '0 : bucket_reg;
        for (int i = HASH_BITS - 1; i >= 0; i--) begin
            rem_wide = {rem, hash_byte[i]};
            if (rem_wide >= BUCKET_WIDE'(BUCKETS)) begin
                rem_wide = rem_wide - BUCKET_WIDE'(BUCKETS);
            end
            rem = rem_wide[BUCKET_W-1:0];
        end
        hash_result = rem;
        // negative key: subtract 2^32 mod buckets, modulo buckets
        if (stat.hash_last && key_reg[KEY_W-1]) begin
            if (rem >= WRAP_MOD) begin
                hash_result = rem - WRAP_MOD;
            end else begin
                rem_wide    = {1'b0, rem} + BUCKET_WIDE'(BUCKETS) - {1'b0, WRAP_MOD};
                hash_result = rem_wide[BUCKET_W-1:0];
            end
        end
    end

    // compare of the way read in the previous cycle
    always_comb begin
        match_now     = rd_pend_reg && valid_reg[slot_of(bucket_reg, cmp_way_reg)]
                        && (key_rd == key_reg);
        hit_now       = hit_reg || match_now;
        hit_way_now   = hit_reg ? hit_way_reg : cmp_way_reg;
        hit_value_now = hit_reg ? hit_value_reg : value_rd;
    end

    // lowest free way of the bucket
    always_comb begin
        free_any = 1'b0;
        free_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            bucket_valid[w] = valid_reg[slot_of(bucket_reg, WAY_W'(w))];
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!bucket_valid[w]) begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end
        free_slot = slot_of(bucket_reg, free_way);
        hit_slot  = slot_of(bucket_reg, hit_way_now);
    end

    always_comb begin
        op_next         = op_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        bucket_next     = bucket_reg;
        hash_cnt_next   = hash_cnt_reg;
        way_next        = way_reg;
        cmp_way_next    = cmp_way_reg;
        rd_pend_next    = cmd.read;
        hit_next        = hit_reg;
        hit_way_next    = hit_way_reg;
        hit_value_next  = hit_value_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        key_wr_en       = 1'b0;
        value_wr_en     = 1'b0;

        if (cmd.accept) begin
            op_next       = op_t'(s_operation);
            key_next      = s_key;
            value_next    = s_value;
            bucket_next   = s_key[BUCKET_W-1:0];
            hash_cnt_next = '0;
            way_next      = '0;
            hit_next      = 1'b0;
        end

        if (cmd.hash_step) begin
            bucket_next   = hash_result;
            hash_cnt_next = hash_cnt_reg + 1'b1;
        end

        if (cmd.read) begin
            way_next     = way_reg + 1'b1;
            cmp_way_next = way_reg;
        end

        if (rd_pend_reg) begin
            hit_next       = hit_now;
            hit_way_next   = hit_way_now;
            hit_value_next = hit_value_now;
        end

        if (cmd.finish) begin
            m_valid_next    = 1'b1;
            status_next     = ST_OK;
            read_value_next = '0;
            case (op_reg)
                OP_INSERT: begin
                    if (hit_now) begin
                        status_next = ST_EXISTS;
                    end else if (free_any) begin
                        key_wr_en             = 1'b1;
                        value_wr_en           = 1'b1;
                        valid_next[free_slot] = 1'b1;
                        count_next            = count_reg + 1'b1;
                    end else begin
                        status_next = ST_FULL;
                    end
                end
                OP_REMOVE: begin
                    if (hit_now) begin
                        valid_next[hit_slot] = 1'b0;
                        count_next           = count_reg - 1'b1;
                    end else begin
                        status_next = ST_MISSING;
                    end
                end
                OP_GET: begin
                    if (hit_now) begin
                        read_value_next = hit_value_now;
                    end else begin
                        status_next = ST_MISSING;
                    end
                end
                OP_EXISTS: begin
                    if (!hit_now) begin
                        status_next = ST_MISSING;
                    end
                end
                OP_UPDATE: begin
                    if (hit_now) begin
                        value_wr_en = 1'b1;
                    end else begin
                        status_next = ST_MISSING;
                    end
                end
                OP_CLEAR: begin
                    valid_next = '0;
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            rd_pend_reg <= rd_pend_next;
            hit_reg     <= hit_next;
        end
        op_reg         <= op_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        bucket_reg     <= bucket_next;
        hash_cnt_reg   <= hash_cnt_next;
        way_reg        <= way_next;
        cmp_way_reg    <= cmp_way_next;
        hit_way_reg    <= hit_way_next;
        hit_value_reg  <= hit_value_next;
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
    end

    hbm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_wr_en),
        .wr_addr (free_slot),
        .wr_data (key_reg),
        .rd_en   (cmd.read),
        .rd_addr (slot_of(bucket_reg, way_reg)),
        .rd_data (key_rd)
    );

    hbm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (value_wr_en),
        .wr_addr ((op_reg == OP_INSERT) ? free_slot : hit_slot),
        .wr_data (value_reg),
        .rd_en   (cmd.read),
        .rd_addr (slot_of(bucket_reg, way_reg)),
        .rd_data (value_rd)
    );

    assign stat.hash_last = (hash_cnt_reg == HASH_CNT_W'(HASH_STEPS - 1));
    assign stat.last_way  = (way_reg == WAY_W'(WAYS - 1));
    assign stat.out_busy  = m_valid_reg && !m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_read_value  = read_value_reg;
    assign m_entry_count = count_reg;

    // entry count tracks the valid bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (SLOTS > 127) || (count_reg == COUNT_W'($countones(valid_reg))))
        else $error("entry count disagrees with valid slots");

    // a waiting result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten while stalled");

    // a successful insert adds exactly one entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && (op_reg == OP_INSERT) && (status_next == ST_OK))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not add one entry");

    // search never overlaps hashing or completion
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.read && cmd.finish) && !(cmd.hash_step && cmd.read))
        else $error("overlapping sequencer commands");

endmodule

FILE: src/bucketed_hash_map.sv
// top level of the bucketed hash map: key-value table with per-bucket way search
//
// requests enter on the s_ channel (s_valid/s_ready): an operation, a key and a value.
// every accepted item gives exactly one result on the m_ channel (m_valid/m_ready):
// a status, the value read by a get, and the entry count after the request.
// a key maps to bucket (key mod BUCKETS), taken as the non-negative remainder;
// only that bucket's WAYS slots are searched, one way per cycle from the key and
// value rams; the result is registered in the finish state, and the next item is
// taken once the sequencer has returned to idle.
// when BUCKETS is not a power of two, a digit-serial remainder unit first folds
// the key into a bucket index, one key byte per cycle.
// one item is in flight at a time; s_ready is high only while the sequencer idles.
// the result sits in an output register: a new item is accepted while it waits,
// and a stalled receiver holds the next item at its final step until m_ready.
// reset clears the valid bits, the entry count and all handshake state at once;
// no clearing pass is needed and the first item is accepted right after reset.
// a clear request drops every entry in its final cycle.
module bucketed_hash_map
    import hbm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_operation,
    input  logic signed [KEY_W-1:0]   s_key,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic signed [VALUE_W-1:0] m_read_value,
    output logic [COUNT_W-1:0]        m_entry_count
);

    // commands from the sequencer, status back from the datapath
    hbm_cmd_t  cmd;
    hbm_stat_t stat;

    hbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hbm_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_operation   (s_operation),
        .s_key         (s_key),
        .s_value       (s_value),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_entry_count (m_entry_count)
    );

endmodule
